FILE: hdl/nca_pkg.sv
// Shared types and constants for the nearest-center assignment block.
package nca_pkg;

    // Fixed field widths of the item, configuration and result channels.
    localparam int IDX_W   = 4;
    localparam int DIM_W   = 4;
    localparam int CFG_W   = 5;
    localparam int DIST_W  = 52;

    // A difference magnitude at or above 2^SQ_LOG2 saturates the square.
    localparam int SQ_LOG2 = 26;

    localparam logic [DIST_W-1:0] SUM_MAX       = {DIST_W{1'b1}};
    localparam logic [CFG_W-1:0]  ACTIVE_RESET  = CFG_W'(16);

    // Command codes of the input item.
    localparam logic CMD_CENTER = 1'b0;
    localparam logic CMD_POINT  = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic center_wr;
        logic issue;
        logic load_out;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic issue_last;
        logic pass_done;
        logic point_last;
        logic out_busy;
    } t_ctrl_stat;

endpackage

FILE: hdl/nca_in_if.sv
// Input item channel: valid/ready handshake with the coordinate payload.
interface nca_in_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [nca_pkg::IDX_W-1:0]     center_index;
    logic [nca_pkg::DIM_W-1:0]     dim_index;
    logic signed [COORD_WIDTH-1:0] coord_value;
    logic                          point_last;

    modport source (
        output valid, cmd, center_index, dim_index, coord_value, point_last,
        input  ready
    );

    modport sink (
        input  valid, cmd, center_index, dim_index, coord_value, point_last,
        output ready
    );
endinterface

FILE: hdl/nca_out_if.sv
// Result channel: valid/ready handshake with the nearest center and its distance.
interface nca_out_if;
    logic                       valid;
    logic                       ready;
    logic [nca_pkg::IDX_W-1:0]  nearest_center;
    logic [nca_pkg::DIST_W-1:0] min_sq_distance;

    modport source (
        output valid, nearest_center, min_sq_distance,
        input  ready
    );

    modport sink (
        input  valid, nearest_center, min_sq_distance,
        output ready
    );
endinterface

FILE: hdl/nca_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module nca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/nca_ctrl.sv
// Sequencer for the center pass: accepts items, steps the datapath, hands off results.
module nca_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_cmd,
    output logic                o_in_ready,
    input  nca_pkg::t_ctrl_stat i_stat,
    output nca_pkg::t_ctrl_cmd  o_cmd
);
    import nca_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && o_in_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_in_cmd == CMD_POINT) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (i_stat.issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_stat.pass_done) begin
                    n_state = i_stat.point_last ? S_RESULT : S_IDLE;
                end
            end
            S_RESULT: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready        = 1'b0;
        o_cmd.capture     = 1'b0;
        o_cmd.center_wr   = 1'b0;
        o_cmd.issue       = 1'b0;
        o_cmd.load_out    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.capture   = i_in_valid && i_in_cmd == CMD_POINT;
                o_cmd.center_wr = i_in_valid && i_in_cmd == CMD_CENTER;
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
            end
            S_DRAIN: begin
            end
            S_RESULT: begin
                o_cmd.load_out = !i_stat.out_busy;
            end
            default: begin
            end
        endcase
    end
endmodule

FILE: hdl/nca_datapath.sv
// Center table, shared squarer and accumulator, running minimum and result register.
module nca_datapath #(
    parameter int MAX_CENTERS = 16,
    parameter int MAX_DIMS    = 16,
    parameter int COORD_WIDTH = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [nca_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic [nca_pkg::IDX_W-1:0]        i_center_index,
    input  logic [nca_pkg::DIM_W-1:0]        i_dim_index,
    input  logic signed [COORD_WIDTH-1:0]    i_coord_value,
    input  logic                             i_point_last,
    input  nca_pkg::t_ctrl_cmd               i_cmd,
    output nca_pkg::t_ctrl_stat              o_stat,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [nca_pkg::IDX_W-1:0]        o_nearest_center,
    output logic [nca_pkg::DIST_W-1:0]       o_min_sq_distance
);
    import nca_pkg::*;

    localparam int KW    = $clog2(MAX_CENTERS);
    localparam int AW    = $clog2(MAX_CENTERS * MAX_DIMS);
    localparam int MW    = COORD_WIDTH + 1;
    localparam logic [KW-1:0] KLAST = KW'(MAX_CENTERS - 1);

    // Configuration and captured point coordinate.
    logic [CFG_W-1:0]              r_active;
    logic signed [COORD_WIDTH-1:0] r_v;
    logic [DIM_W-1:0]              r_di;
    logic                          r_di_ok;
    logic                          r_last;
    logic                          r_fresh;

    // Pass pipeline.
    logic [KW-1:0]        r_k;
    logic                 r_v1, r_v2, r_v3;
    logic [KW-1:0]        r_k1, r_k2, r_k3;
    logic [SQ_LOG2-1:0]   r_mag;
    logic                 r_sat;
    logic [DIST_W-1:0]    r_sq;

    // Running minimum and result register.
    logic [DIST_W-1:0]    r_best;
    logic [KW-1:0]        r_best_k;
    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_out_idx;
    logic [DIST_W-1:0]    r_out_dist;

    logic                          wr_ok;
    logic [AW-1:0]                 center_waddr;
    logic [AW-1:0]                 center_raddr;
    logic signed [COORD_WIDTH-1:0] center_rd;
    logic signed [MW-1:0]          s1_diff;
    logic [MW-1:0]                 s1_mag;
    logic                          s1_sat;
    logic [DIST_W-1:0]             s2_prod;
    logic [DIST_W-1:0]             sum_rd;
    logic [DIST_W-1:0]             s3_base;
    logic [DIST_W-1:0]             s3_add;
    logic [DIST_W:0]               s3_sum;
    logic [DIST_W-1:0]             s3_new;
    logic                          s3_active;
    logic                          pass_done;

    // Center table: written by center items, read once per center during a pass.
    assign wr_ok = (int'(i_center_index) < MAX_CENTERS) && (int'(i_dim_index) < MAX_DIMS);
    assign center_waddr = AW'(i_center_index) * AW'(MAX_DIMS) + AW'(i_dim_index);
    assign center_raddr = AW'(r_k) * AW'(MAX_DIMS) + AW'(r_di);

    nca_ram #(
        .WIDTH (COORD_WIDTH),
        .DEPTH (MAX_CENTERS * MAX_DIMS)
    ) u_center_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.center_wr && wr_ok),
        .i_waddr (center_waddr),
        .i_wdata (i_coord_value),
        .i_raddr (center_raddr),
        .o_rdata (center_rd)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    // Capture the point coordinate and step the center counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_v     <= i_coord_value;
            r_di    <= i_dim_index;
            r_di_ok <= int'(i_dim_index) < MAX_DIMS;
            r_last  <= i_point_last;
        end
        if (i_cmd.capture) begin
            r_k <= '0;
        end else if (i_cmd.issue) begin
            r_k <= r_k + 1'b1;
        end
    end

    // Pipeline valid bits and the sums-are-zero flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_fresh <= 1'b1;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.load_out) begin
                r_fresh <= 1'b1;
            end else if (pass_done) begin
                r_fresh <= 1'b0;
            end
        end
    end

    // Stage 1: difference magnitude and saturation check.
    assign s1_diff = {r_v[COORD_WIDTH-1], r_v} - {center_rd[COORD_WIDTH-1], center_rd};
    assign s1_mag  = s1_diff[MW-1] ? MW'(-s1_diff) : MW'(s1_diff);
    assign s1_sat  = (s1_mag >> SQ_LOG2) != '0;

    // Stage 2: square of the magnitude.
    assign s2_prod = r_mag * r_mag;

    always_ff @(posedge i_clk) begin
        r_k1  <= r_k;
        r_k2  <= r_k1;
        r_k3  <= r_k2;
        r_mag <= SQ_LOG2'(s1_mag);
        r_sat <= s1_sat;
        r_sq  <= r_sat ? SUM_MAX : s2_prod;
    end

    // Running sums, one per center.
    nca_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_CENTERS)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (r_v3),
        .i_waddr (r_k3),
        .i_wdata (s3_new),
        .i_raddr (r_k2),
        .o_rdata (sum_rd)
    );

    // Stage 3: saturating accumulate.
    assign s3_base   = r_fresh ? '0 : sum_rd;
    assign s3_add    = r_di_ok ? r_sq : '0;
    assign s3_sum    = {1'b0, s3_base} + {1'b0, s3_add};
    assign s3_new    = s3_sum[DIST_W] ? SUM_MAX : s3_sum[DIST_W-1:0];
    assign s3_active = (r_k3 == '0) || (int'(r_k3) < int'(r_active));
    assign pass_done = r_v3 && (r_k3 == KLAST);

    // Running minimum over the active centers; strict compare keeps the lowest index.
    always_ff @(posedge i_clk) begin
        if (r_v3) begin
            if (r_k3 == '0) begin
                r_best   <= s3_new;
                r_best_k <= '0;
            end else if (s3_active && s3_new < r_best) begin
                r_best   <= s3_new;
                r_best_k <= r_k3;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_idx  <= IDX_W'(r_best_k);
            r_out_dist <= r_best;
        end
    end

    assign o_stat.issue_last = r_k == KLAST;
    assign o_stat.pass_done  = pass_done;
    assign o_stat.point_last = r_last;
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_nearest_center  = r_out_idx;
    assign o_min_sq_distance = r_out_dist;
endmodule

FILE: hdl/nearest_center_assign_core.sv
// Top level of the nearest-center assignment block.
//
//  Channel   Direction  Transfer carries
//  i_item    in         cmd, center_index, dim_index, coord_value, point_last
//  o_result  out        nearest_center, min_sq_distance
//  i_cfg_*   in         active_centers (write only)
//
// Each point coordinate makes one pass over the centers:
// one shared squarer and accumulator visits every center in turn, one per cycle,
// through the single read port of the center memory, behind a three-stage pipeline.
// After the last coordinate of a point, a result state loads the result register.
// Reset is synchronous; the center memory is not cleared and there is no startup pass.
// A waiting result holds the output while further items are taken; only a second
// result stalls until the first transfer completes.
module nearest_center_assign_core #(
    parameter int MAX_CENTERS = 16,
    parameter int MAX_DIMS    = 16,
    parameter int COORD_WIDTH = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nca_pkg::CFG_W-1:0]   i_cfg_wdata,
    nca_in_if.sink                      i_item,
    nca_out_if.source                   o_result
);
    import nca_pkg::*;

    t_ctrl_cmd  ctrl_cmd;
    t_ctrl_stat ctrl_stat;

    // Sequencer.
    nca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_cmd   (i_item.cmd),
        .o_in_ready (i_item.ready),
        .i_stat     (ctrl_stat),
        .o_cmd      (ctrl_cmd)
    );

    // Datapath.
    nca_datapath #(
        .MAX_CENTERS (MAX_CENTERS),
        .MAX_DIMS    (MAX_DIMS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_center_index    (i_item.center_index),
        .i_dim_index       (i_item.dim_index),
        .i_coord_value     (i_item.coord_value),
        .i_point_last      (i_item.point_last),
        .i_cmd             (ctrl_cmd),
        .o_stat            (ctrl_stat),
        .o_out_valid       (o_result.valid),
        .i_out_ready       (o_result.ready),
        .o_nearest_center  (o_result.nearest_center),
        .o_min_sq_distance (o_result.min_sq_distance)
    );
endmodule

FILE: verif/tb_nearest_center_assign_core.sv
// Self-checking testbench for the nearest-center assignment core.
`timescale 1ns / 1ps

module tb_nearest_center_assign_core;
    import nca_pkg::*;

    localparam int N_CENTERS    = 16;
    localparam int N_DIMS       = 16;
    localparam int COORD_W      = 24;
    localparam int DRAIN_CYCLES = 32;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 700;
    localparam int HOLD_AFTER   = 20;

    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_CHOPPY,
        RX_SPARSE
    } t_rx_mode;

    typedef struct {
        logic                      cmd;
        logic [IDX_W-1:0]          center_index;
        logic [DIM_W-1:0]          dim_index;
        logic signed [COORD_W-1:0] coord_value;
        logic                      point_last;
    } t_coord_item;

    typedef struct {
        logic [IDX_W-1:0]  nearest_center;
        logic [DIST_W-1:0] min_sq_distance;
    } t_nearest_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    nca_in_if #(.COORD_WIDTH(COORD_W)) item_if ();
    nca_out_if                         result_if ();

    nearest_center_assign_core #(
        .MAX_CENTERS(N_CENTERS),
        .MAX_DIMS   (N_DIMS),
        .COORD_WIDTH(COORD_W)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    // Predictor state: center table, per-center running sums and the active count.
    logic signed [COORD_W-1:0] ctr_table [N_CENTERS][N_DIMS];
    logic [DIST_W-1:0]         dist_acc  [N_CENTERS];
    logic [CFG_W-1:0]          active_cfg;

    // Shadow of the table as the stimulus generator has queued it.
    logic signed [COORD_W-1:0] gen_centers [N_CENTERS][N_DIMS];

    t_coord_item     pending_coords[$];
    t_nearest_result expected_nearest[$];
    t_coord_item     cur_item;
    t_nearest_result got_result;
    t_nearest_result want_result;

    int       error_count;
    int       results_seen;
    int       burst_left;
    int       gap_left;
    int       idle_cycles;
    int       hold_left;
    bit       hold_done;
    int       rx_mode_left;
    t_rx_mode rx_mode;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Predict the effect of one accepted item on the sums and the result stream.
    task automatic update_distances(input t_coord_item it);
        logic signed [63:0] diff;
        logic [63:0]        mag;
        logic [63:0]        sq;
        logic [63:0]        sum;
        int                 n_active;
        int                 best;
        logic [DIST_W-1:0]  best_d;
        t_nearest_result    res;
        if (it.cmd == CMD_CENTER) begin
            ctr_table[it.center_index][it.dim_index] = it.coord_value;
        end else begin
            for (int k = 0; k < N_CENTERS; k++) begin
                diff = it.coord_value - ctr_table[k][it.dim_index];
                mag  = (diff < 0) ? -diff : diff;
                sq   = (mag >= (64'd1 << SQ_LOG2)) ? 64'(SUM_MAX) : mag * mag;
                sum  = 64'(dist_acc[k]) + sq;
                dist_acc[k] = (sum > 64'(SUM_MAX)) ? SUM_MAX : sum[DIST_W-1:0];
            end
            if (it.point_last) begin
                // A zero count acts as one; counts above the table size are clipped.
                n_active = int'(active_cfg);
                if (n_active == 0) n_active = 1;
                if (n_active > N_CENTERS) n_active = N_CENTERS;
                best   = 0;
                best_d = dist_acc[0];
                for (int k = 1; k < n_active; k++) begin
                    if (dist_acc[k] < best_d) begin
                        best_d = dist_acc[k];
                        best   = k;
                    end
                end
                res.nearest_center  = IDX_W'(best);
                res.min_sq_distance = best_d;
                expected_nearest.push_back(res);
                for (int k = 0; k < N_CENTERS; k++) dist_acc[k] = '0;
            end
        end
    endtask

    function automatic logic signed [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return COORD_W'($urandom_range(0, 32) - 16);
            default: return COORD_W'($urandom());
        endcase
    endfunction

    // A value close to a center coordinate, so that the winner varies and ties occur.
    function automatic logic signed [COORD_W-1:0] near_coord(
        input logic signed [COORD_W-1:0] base
    );
        case ($urandom_range(0, 5))
            0:       return base;
            1:       return COORD_W'(int'(base) + $urandom_range(0, 32) - 16);
            2:       return COORD_W'(int'(base) + $urandom_range(0, 8192) - 4096);
            3:       return random_coord();
            default: return COORD_W'(int'(base) + $urandom_range(0, 1 << 18) - (1 << 17));
        endcase
    endfunction

    task automatic push_center(input int c, input int d,
                               input logic signed [COORD_W-1:0] v, input logic last);
        t_coord_item it;
        it.cmd          = CMD_CENTER;
        it.center_index = IDX_W'(c);
        it.dim_index    = DIM_W'(d);
        it.coord_value  = v;
        it.point_last   = last;
        gen_centers[c][d] = v;
        pending_coords.push_back(it);
    endtask

    task automatic push_coord(input int d, input logic signed [COORD_W-1:0] v,
                              input logic last);
        t_coord_item it;
        it.cmd          = CMD_POINT;
        it.center_index = IDX_W'($urandom_range(0, N_CENTERS - 1));
        it.dim_index    = DIM_W'(d);
        it.coord_value  = v;
        it.point_last   = last;
        pending_coords.push_back(it);
    endtask

    task automatic push_random_center();
        int c;
        int d;
        logic signed [COORD_W-1:0] v;
        c = $urandom_range(0, N_CENTERS - 1);
        d = $urandom_range(0, N_DIMS - 1);
        // Copying another center's coordinate makes equal distances likely.
        if ($urandom_range(0, 9) < 3)
            v = gen_centers[$urandom_range(0, N_CENTERS - 1)][d];
        else
            v = random_coord();
        push_center(c, d, v, logic'($urandom_range(0, 1)));
    endtask

    // Mostly whole points aimed near one center, with center updates mixed in.
    task automatic add_random_traffic(input int n_items);
        int made;
        int m;
        int k;
        int d;
        bit in_order;
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    push_random_center();
                    made++;
                end
            end else begin
                m = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 24) : $urandom_range(1, 8);
                k = $urandom_range(0, N_CENTERS - 1);
                in_order = ($urandom_range(0, 3) != 0);
                for (int i = 0; i < m; i++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        push_random_center();
                        made++;
                    end
                    d = in_order ? (i % N_DIMS) : $urandom_range(0, N_DIMS - 1);
                    push_coord(d, near_coord(gen_centers[k][d]), i == m - 1);
                    made++;
                end
            end
        end
    endtask

    task automatic set_active_centers(input logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        active_cfg = v;
        @(negedge i_clk);
    endtask

    // Wait until every queued item is taken and every result has come back.
    task automatic wait_idle();
        while (pending_coords.size() != 0 || item_if.valid || expected_nearest.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Sequence of phases: table load and directed points, then random phases.
    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        item_if.valid        = 1'b0;
        item_if.cmd          = CMD_CENTER;
        item_if.center_index = '0;
        item_if.dim_index    = '0;
        item_if.coord_value  = '0;
        item_if.point_last   = 1'b0;
        result_if.ready      = 1'b0;
        active_cfg  = ACTIVE_RESET;
        error_count = 0;
        results_seen = 0;
        burst_left  = 0;
        gap_left    = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        rx_mode_left = 0;
        rx_mode     = RX_OPEN;
        for (int k = 0; k < N_CENTERS; k++) dist_acc[k] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill the whole table so no point ever reads an unwritten entry.
        for (int c = 0; c < N_CENTERS; c++)
            for (int d = 0; d < N_DIMS; d++)
                push_center(c, d, (c == 0 && d == 0) ? COORD_MIN : random_coord(),
                            logic'($urandom_range(0, 1)));

        // Two equal centers: the lower index must win the tie.
        push_center(2, 0, COORD_W'(100), 1'b0);
        push_center(5, 0, COORD_W'(100), 1'b1);
        push_coord(0, COORD_W'(100), 1'b1);

        // A point sitting exactly on one center over its first dimensions.
        for (int d = 0; d < 8; d++)
            push_coord(d, gen_centers[9][d], d == 7);
        wait_idle();

        // One active center and a repeated extreme dimension drive the sum to saturation.
        set_active_centers(CFG_W'(1));
        for (int i = 0; i < 17; i++)
            push_coord(0, COORD_MAX, i == 16);
        wait_idle();

        set_active_centers(CFG_W'(16));
        add_random_traffic(100);
        wait_idle();

        set_active_centers(CFG_W'(0));
        add_random_traffic(70);
        wait_idle();

        set_active_centers(CFG_W'(31));
        add_random_traffic(70);
        wait_idle();

        set_active_centers(CFG_W'(2));
        add_random_traffic(70);
        wait_idle();

        repeat (5) begin
            set_active_centers(CFG_W'($urandom_range(1, 16)));
            add_random_traffic(85);
            wait_idle();
        end

        if (error_count == 0) begin
            $display("tb_nearest_center_assign_core: clean");
        end else begin
            $display("tb_nearest_center_assign_core: errors");
        end
        $finish;
    end

    // Item driver: bursts of transfers separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                update_distances(cur_item);
            end
            if (!item_if.valid || item_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    item_if.valid <= 1'b0;
                end else if (pending_coords.size() != 0) begin
                    cur_item = pending_coords.pop_front();
                    item_if.valid        <= 1'b1;
                    item_if.cmd          <= cur_item.cmd;
                    item_if.center_index <= cur_item.center_index;
                    item_if.dim_index    <= cur_item.dim_index;
                    item_if.coord_value  <= cur_item.coord_value;
                    item_if.point_last   <= cur_item.point_last;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: changing stall patterns, plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            result_if.ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            result_if.ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 2));
                rx_mode_left = $urandom_range(16, 96);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_OPEN:   result_if.ready <= 1'b1;
                RX_CHOPPY: result_if.ready <= logic'($urandom_range(0, 1));
                default:   result_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Result checker: each transfer is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got_result.nearest_center  = result_if.nearest_center;
            got_result.min_sq_distance = result_if.min_sq_distance;
            results_seen++;
            if (expected_nearest.size() == 0) begin
                $display("%0t: unexpected result, actual center %0d distance %0d",
                         $time, got_result.nearest_center, got_result.min_sq_distance);
                error_count++;
            end else begin
                want_result = expected_nearest.pop_front();
                if (got_result.nearest_center !== want_result.nearest_center) begin
                    $display("%0t: nearest_center expected %0d actual %0d",
                             $time, want_result.nearest_center, got_result.nearest_center);
                    error_count++;
                end
                if (got_result.min_sq_distance !== want_result.min_sq_distance) begin
                    $display("%0t: min_sq_distance expected %0d actual %0d",
                             $time, want_result.min_sq_distance,
                             got_result.min_sq_distance);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, expected_nearest.size());
                $display("tb_nearest_center_assign_core: errors");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

endmodule

FILE: filelist.f
hdl/nca_pkg.sv
hdl/nca_in_if.sv
hdl/nca_out_if.sv
hdl/nca_ram.sv
hdl/nca_ctrl.sv
hdl/nca_datapath.sv
hdl/nearest_center_assign_core.sv
verif/tb_nearest_center_assign_core.sv
